@@ hdl/bbpid_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// bbpid_pkg - shared types and constants of the booster position controller
// Field widths, fixed-point coefficients, register map, datapath commands.
// ============================================================================
package bbpid_pkg;

    // Field and register widths
    localparam int ADC_W      = 12;
    localparam int POS_W      = 16;
    localparam int DEV_W      = 22;
    localparam int INT_W      = 32;
    localparam int GAIN_W     = 16;
    localparam int LIM_W      = 15;
    localparam int DRV_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Shared multiplier: signed operand A times unsigned 16-bit coefficient
    localparam int MUL_A_W = INT_W + 1;
    localparam int MUL_B_W = GAIN_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int SUM_W   = PROD_W + 2;

    // Curve and leak coefficients (Q0.16 slopes, Q8.8 offsets)
    localparam logic [15:0] K_077  = 16'd50463;
    localparam logic [15:0] K_292  = 16'd748;
    localparam logic [15:0] K_059  = 16'd38666;
    localparam logic [15:0] K_482  = 16'd1234;
    localparam logic [15:0] K_160  = 16'd410;
    localparam logic [15:0] K_LIFT = 16'd512;
    localparam logic [15:0] K_200  = 16'd512;
    localparam logic [15:0] K_095  = 16'd62259;
    localparam logic [15:0] K_0994 = 16'd65143;

    // Register map
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFFSET   = 3'd0,
        CFG_SCALE    = 3'd1,
        CFG_BREAK_LO = 3'd2,
        CFG_BREAK_HI = 3'd3,
        CFG_GAIN_P   = 3'd4,
        CFG_GAIN_I   = 3'd5,
        CFG_GAIN_D   = 3'd6,
        CFG_LIMIT    = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [ADC_W-1:0]  offset;
        logic [15:0]       scale;
        logic [POS_W-1:0]  b1;
        logic [POS_W-1:0]  b2;
        logic [POS_W-1:0]  b3;
        logic [POS_W-1:0]  b4;
        logic [GAIN_W-1:0] gain_p;
        logic [GAIN_W-1:0] gain_i;
        logic [GAIN_W-1:0] gain_d;
        logic [LIM_W-1:0]  limit;
    } t_cfg;

    // Multiplier operand selection
    typedef enum logic [2:0] {
        MUL_POS = 3'd0,
        MUL_CRV = 3'd1,
        MUL_INT = 3'd2,
        MUL_P   = 3'd3,
        MUL_I   = 3'd4,
        MUL_D   = 3'd5
    } t_mul_sel;

    // Controller to datapath command word
    typedef struct packed {
        logic     cap_span;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     ld_pos;
        logic     ld_sp;
        logic     int_upd;
        logic     sum_ld;
        logic     sum_add;
        logic     ld_out;
    } t_cmd;

endpackage

@@ hdl/bbpid_in_if.sv @@
`timescale 1ns / 1ps
// ============================================================================
// bbpid_in_if - sample channel
// Valid/ready channel carrying one cylinder ADC sample per word.
// ============================================================================
interface bbpid_in_if;
    import bbpid_pkg::*;

    logic             valid;
    logic             ready;
    logic [ADC_W-1:0] cylinder_adc;

    modport source (output valid, output cylinder_adc, input ready);
    modport sink   (input valid, input cylinder_adc, output ready);
endinterface

@@ hdl/bbpid_out_if.sv @@
`timescale 1ns / 1ps
// ============================================================================
// bbpid_out_if - result channel
// Valid/ready channel carrying drive increment, position and setpoint.
// ============================================================================
interface bbpid_out_if;
    import bbpid_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [DRV_W-1:0] drive_increment;
    logic [POS_W-1:0]        position;
    logic [POS_W-1:0]        setpoint;
    logic                    limited;

    modport source (output valid, output drive_increment, output position,
                    output setpoint, output limited, input ready);
    modport sink   (input valid, input drive_increment, input position,
                    input setpoint, input limited, output ready);
endinterface

@@ hdl/bbpid_cfg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// bbpid_cfg - configuration register file
// Write-only registers loaded through a plain indexed write port.
// ============================================================================
module bbpid_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [bbpid_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [bbpid_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output bbpid_pkg::t_cfg                    o_cfg
);
    import bbpid_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Decode the write
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_OFFSET:   n_cfg.offset = i_cfg_data[ADC_W-1:0];
                CFG_SCALE:    n_cfg.scale  = i_cfg_data[15:0];
                CFG_BREAK_LO: begin
                    n_cfg.b1 = i_cfg_data[15:0];
                    n_cfg.b2 = i_cfg_data[31:16];
                end
                CFG_BREAK_HI: begin
                    n_cfg.b3 = i_cfg_data[15:0];
                    n_cfg.b4 = i_cfg_data[31:16];
                end
                CFG_GAIN_P:   n_cfg.gain_p = i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_I:   n_cfg.gain_i = i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_D:   n_cfg.gain_d = i_cfg_data[GAIN_W-1:0];
                CFG_LIMIT:    n_cfg.limit  = i_cfg_data[LIM_W-1:0];
                default:      n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ hdl/bbpid_ctrl.sv @@
`timescale 1ns / 1ps
// ============================================================================
// bbpid_ctrl - step sequencer
// One-hot state machine that walks the datapath through one sample and owns
// the channel handshakes.
// ============================================================================
module bbpid_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_out_ready,
    output logic            o_in_ready,
    output logic            o_out_valid,
    output bbpid_pkg::t_cmd o_cmd
);
    import bbpid_pkg::*;

    typedef enum logic [11:0] {
        ST_IDLE = 12'b0000_0000_0001,
        ST_MPOS = 12'b0000_0000_0010,
        ST_POS  = 12'b0000_0000_0100,
        ST_MCRV = 12'b0000_0000_1000,
        ST_SP   = 12'b0000_0001_0000,
        ST_MINT = 12'b0000_0010_0000,
        ST_INT  = 12'b0000_0100_0000,
        ST_MP   = 12'b0000_1000_0000,
        ST_MI   = 12'b0001_0000_0000,
        ST_MD   = 12'b0010_0000_0000,
        ST_SUM  = 12'b0100_0000_0000,
        ST_OUT  = 12'b1000_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_vld;
    logic   n_out_vld;
    logic   w_go;
    t_cmd   w_cmd;

    // Result slot is free when empty or being taken this cycle
    assign w_go = !r_out_vld || i_out_ready;

    // Advance through the steps and issue commands
    always_comb begin
        n_state       = r_state;
        w_cmd         = '0;
        w_cmd.mul_sel = MUL_POS;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.cap_span = 1'b1;
                    n_state        = ST_MPOS;
                end
            end
            ST_MPOS: begin
                w_cmd.mul_en  = 1'b1;
                w_cmd.mul_sel = MUL_POS;
                n_state       = ST_POS;
            end
            ST_POS: begin
                w_cmd.ld_pos = 1'b1;
                n_state      = ST_MCRV;
            end
            ST_MCRV: begin
                w_cmd.mul_en  = 1'b1;
                w_cmd.mul_sel = MUL_CRV;
                n_state       = ST_SP;
            end
            ST_SP: begin
                w_cmd.ld_sp = 1'b1;
                n_state     = ST_MINT;
            end
            ST_MINT: begin
                w_cmd.mul_en  = 1'b1;
                w_cmd.mul_sel = MUL_INT;
                n_state       = ST_INT;
            end
            ST_INT: begin
                w_cmd.int_upd = 1'b1;
                n_state       = ST_MP;
            end
            ST_MP: begin
                w_cmd.mul_en  = 1'b1;
                w_cmd.mul_sel = MUL_P;
                n_state       = ST_MI;
            end
            ST_MI: begin
                w_cmd.mul_en  = 1'b1;
                w_cmd.mul_sel = MUL_I;
                w_cmd.sum_ld  = 1'b1;
                n_state       = ST_MD;
            end
            ST_MD: begin
                w_cmd.mul_en  = 1'b1;
                w_cmd.mul_sel = MUL_D;
                w_cmd.sum_add = 1'b1;
                n_state       = ST_SUM;
            end
            ST_SUM: begin
                w_cmd.sum_add = 1'b1;
                n_state       = ST_OUT;
            end
            ST_OUT: begin
                if (w_go) begin
                    w_cmd.ld_out = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Hold the result word until it is taken
    always_comb begin
        n_out_vld = r_out_vld;
        if (w_cmd.ld_out) begin
            n_out_vld = 1'b1;
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_cmd       = w_cmd;

endmodule

@@ hdl/bbpid_dp.sv @@
`timescale 1ns / 1ps
// ============================================================================
// bbpid_dp - controller datapath
// Position scaling, setpoint curve, leaky integral and PID sum around one
// shared 33x17 multiplier with a registered product.
// ============================================================================
module bbpid_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  bbpid_pkg::t_cmd                      i_cmd,
    input  bbpid_pkg::t_cfg                      i_cfg,
    input  logic [bbpid_pkg::ADC_W-1:0]          i_adc,
    output logic signed [bbpid_pkg::DRV_W-1:0]   o_drive_increment,
    output logic [bbpid_pkg::POS_W-1:0]          o_position,
    output logic [bbpid_pkg::POS_W-1:0]          o_setpoint,
    output logic                                 o_limited
);
    import bbpid_pkg::*;

    typedef enum logic [2:0] {
        SEG_ZERO  = 3'd0,
        SEG_LIFT  = 3'd1,
        SEG_STEEP = 3'd2,
        SEG_FLAT  = 3'd3,
        SEG_TAIL  = 3'd4
    } t_seg;

    logic [ADC_W-1:0]         r_span;
    logic signed [PROD_W-1:0] r_prod;
    logic [POS_W-1:0]         r_pos;
    t_seg                     r_seg;
    logic [POS_W-1:0]         r_sp;
    logic signed [DEV_W-1:0]  r_dev;
    logic signed [DEV_W-1:0]  r_prev;
    logic signed [INT_W-1:0]  r_int;
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [DRV_W-1:0]  r_out_drv;
    logic [POS_W-1:0]         r_out_pos;
    logic [POS_W-1:0]         r_out_sp;
    logic                     r_out_lim;

    t_seg                     w_seg;
    logic signed [MUL_A_W-1:0] w_a;
    logic signed [MUL_B_W-1:0] w_b;
    logic signed [PROD_W-1:0] w_mul;
    logic signed [DEV_W:0]    w_dd;
    logic [POS_W-1:0]         w_pos;
    logic [POS_W:0]           w_sp_wide;
    logic [POS_W-1:0]         w_sp;
    logic signed [POS_W:0]    w_diff;
    logic signed [DEV_W-1:0]  w_dev;
    logic                     w_int_en;
    logic signed [INT_W+2:0]  w_acc;
    logic signed [INT_W-1:0]  w_acc_sat;
    logic signed [SUM_W-1:0]  w_prod_ext;
    logic signed [SUM_W-1:0]  w_round;
    logic signed [SUM_W-17:0] w_q;
    logic signed [DRV_W-1:0]  w_sat;
    logic signed [DRV_W-1:0]  w_lim;
    logic signed [DRV_W-1:0]  w_drv;
    logic                     w_limited;

    // Curve segment of the current position, first passing test wins
    always_comb begin
        if (r_pos < i_cfg.b1) begin
            w_seg = SEG_ZERO;
        end else if (r_pos < i_cfg.b2) begin
            w_seg = SEG_LIFT;
        end else if (r_pos < i_cfg.b3) begin
            w_seg = SEG_STEEP;
        end else if (r_pos < i_cfg.b4) begin
            w_seg = SEG_FLAT;
        end else begin
            w_seg = SEG_TAIL;
        end
    end

    // Select multiplier operands
    assign w_dd = {r_dev[DEV_W-1], r_dev} - {r_prev[DEV_W-1], r_prev};

    always_comb begin
        case (i_cmd.mul_sel)
            MUL_POS: begin
                w_a = MUL_A_W'(r_span);
                w_b = {1'b0, i_cfg.scale};
            end
            MUL_CRV: begin
                w_a = MUL_A_W'(r_pos);
                w_b = {1'b0, (w_seg == SEG_FLAT) ? K_059 : K_077};
            end
            MUL_INT: begin
                w_a = MUL_A_W'(r_int);
                w_b = {1'b0, (r_sp == '0) ? K_095 : K_0994};
            end
            MUL_P: begin
                w_a = MUL_A_W'(r_dev);
                w_b = {1'b0, i_cfg.gain_p};
            end
            MUL_I: begin
                w_a = MUL_A_W'(r_int);
                w_b = {1'b0, i_cfg.gain_i};
            end
            MUL_D: begin
                w_a = MUL_A_W'(w_dd);
                w_b = {1'b0, i_cfg.gain_d};
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    assign w_mul = w_a * w_b;

    // Saturate the scaled travel to Q8.8
    assign w_pos = (|r_prod[27:24]) ? {POS_W{1'b1}} : r_prod[23:8];

    // Evaluate the setpoint curve
    always_comb begin
        case (r_seg)
            SEG_ZERO:  w_sp_wide = '0;
            SEG_LIFT:  w_sp_wide = {1'b0, r_pos} + {1'b0, K_LIFT};
            SEG_STEEP: w_sp_wide = {1'b0, r_prod[31:16]} + {1'b0, K_292};
            SEG_FLAT:  w_sp_wide = {1'b0, r_prod[31:16]} + {1'b0, K_482};
            SEG_TAIL:  w_sp_wide = (r_pos >= K_160) ? {1'b0, r_pos - K_160} : '0;
            default:   w_sp_wide = '0;
        endcase
    end

    assign w_sp   = w_sp_wide[POS_W] ? {POS_W{1'b1}} : w_sp_wide[POS_W-1:0];
    assign w_diff = $signed({1'b0, w_sp}) - $signed({1'b0, r_pos});
    assign w_dev  = (DEV_W'(w_diff) <<< 3) + (DEV_W'(w_diff) <<< 1);

    // Leaky integral: floor of the scaled product plus deviation, saturated
    assign w_int_en = (r_sp == '0)
                   || (r_dev >= $signed(DEV_W'(K_200)))
                   || (r_dev <= -$signed(DEV_W'(K_200)));
    assign w_acc = (INT_W+3)'($signed(r_prod[PROD_W-1:16])) + (INT_W+3)'(r_dev);

    always_comb begin
        if (w_acc[INT_W+2:INT_W-1] == '0 || w_acc[INT_W+2:INT_W-1] == '1) begin
            w_acc_sat = w_acc[INT_W-1:0];
        end else if (w_acc[INT_W+2]) begin
            w_acc_sat = {1'b1, {(INT_W-1){1'b0}}};
        end else begin
            w_acc_sat = {1'b0, {(INT_W-1){1'b1}}};
        end
    end

    // Truncate the Q16.16 sum toward zero, saturate, clamp to the limit
    assign w_prod_ext = SUM_W'(r_prod);
    assign w_round    = r_sum + {{(SUM_W-16){1'b0}}, {16{r_sum[SUM_W-1]}}};
    assign w_q        = w_round[SUM_W-1:16];
    assign w_lim      = $signed({1'b0, i_cfg.limit});

    always_comb begin
        if (w_q[SUM_W-17:DRV_W-1] == '0 || w_q[SUM_W-17:DRV_W-1] == '1) begin
            w_sat = w_q[DRV_W-1:0];
        end else if (w_q[SUM_W-17]) begin
            w_sat = {1'b1, {(DRV_W-1){1'b0}}};
        end else begin
            w_sat = {1'b0, {(DRV_W-1){1'b1}}};
        end
    end

    always_comb begin
        w_drv     = w_sat;
        w_limited = 1'b0;
        if (w_sat > w_lim) begin
            w_drv     = w_lim;
            w_limited = 1'b1;
        end else if (w_sat < -w_lim) begin
            w_drv     = -w_lim;
            w_limited = 1'b1;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_span) begin
            r_span <= (i_adc > i_cfg.offset) ? (i_adc - i_cfg.offset) : '0;
        end
        if (i_cmd.mul_en) begin
            r_prod <= w_mul;
        end
        if (i_cmd.mul_en && i_cmd.mul_sel == MUL_CRV) begin
            r_seg <= w_seg;
        end
        if (i_cmd.ld_pos) begin
            r_pos <= w_pos;
        end
        if (i_cmd.ld_sp) begin
            r_sp  <= w_sp;
            r_dev <= w_dev;
        end
        if (i_cmd.sum_ld) begin
            r_sum <= w_prod_ext;
        end else if (i_cmd.sum_add) begin
            r_sum <= r_sum + w_prod_ext;
        end
        if (i_cmd.ld_out) begin
            r_out_drv <= w_drv;
            r_out_pos <= r_pos;
            r_out_sp  <= r_sp;
            r_out_lim <= w_limited;
        end
    end

    // Controller state carried from sample to sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_int  <= '0;
            r_prev <= '0;
        end else begin
            if (i_cmd.int_upd && w_int_en) begin
                r_int <= w_acc_sat;
            end
            if (i_cmd.ld_out) begin
                r_prev <= r_dev;
            end
        end
    end

    assign o_drive_increment = r_out_drv;
    assign o_position        = r_out_pos;
    assign o_setpoint        = r_out_sp;
    assign o_limited         = r_out_lim;

endmodule

@@ hdl/brake_booster_position_pid.sv @@
`timescale 1ns / 1ps
// ============================================================================
// brake_booster_position_pid - brake booster cylinder position controller
// Scales a cylinder travel sample, looks up the setpoint curve and runs a
// positional PID with a leaky, saturating integral.
// ============================================================================
//  channel   dir  handshake           word
//  i_in      in   valid/ready         cylinder_adc
//  o_out     out  valid/ready         drive_increment, position, setpoint,
//                                     limited
//  i_cfg_*   in   write enable only   register index, write data
//
//  A sample reaches the output register after six passes through the one
//  shared 33x17 multiplier; the next word is taken only in the idle step.
//  One sample is in work at a time; the next is accepted once the result is
//  registered, while that result may still wait to be taken.
//  A stalled output holds the finished step until the slot is free.
//  Reset clears the registers, the integral and the previous deviation.
// ============================================================================
module brake_booster_position_pid (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    bbpid_in_if.sink                            i_in,
    bbpid_out_if.source                         o_out,
    input  logic                                i_cfg_we,
    input  logic [bbpid_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [bbpid_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import bbpid_pkg::*;

    t_cfg w_cfg;
    t_cmd w_cmd;

    bbpid_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    bbpid_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (w_cmd)
    );

    bbpid_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .i_cfg             (w_cfg),
        .i_adc             (i_in.cylinder_adc),
        .o_drive_increment (o_out.drive_increment),
        .o_position        (o_out.position),
        .o_setpoint        (o_out.setpoint),
        .o_limited         (o_out.limited)
    );

endmodule

@@ bench/brake_booster_position_pid_test.sv @@
`timescale 1ns / 1ps
// ============================================================================
// brake_booster_position_pid_test - testbench of the booster position PID
// Feeds cylinder ADC words through valid/ready with bursts and gaps, stalls
// the result channel on a random pattern, predicts every result with a
// fixed-point model of the scaling, setpoint curve and leaky PID, and
// compares each result word field by field. Runs directed register settings
// first, then random settings with random and ramping sample streams.
// ============================================================================
module brake_booster_position_pid_test;
    import bbpid_pkg::*;

    localparam int SETTLE_CYCLES = 24;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_WORDS   = 150;

    typedef struct packed {
        logic [DRV_W-1:0] drive_increment;
        logic [POS_W-1:0] position;
        logic [POS_W-1:0] setpoint;
        logic             limited;
    } t_pid_result;

    logic                  i_clk;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    t_cfg_idx              i_cfg_idx  = CFG_OFFSET;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    bbpid_in_if  adc_ch ();
    bbpid_out_if drive_ch ();

    brake_booster_position_pid uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (adc_ch),
        .o_out      (drive_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Controller model state and register copy
    t_cfg        model_cfg = '0;
    int          integral_q = 0;
    int          prev_dev_q = 0;

    logic [ADC_W-1:0] adc_words_q[$];
    t_pid_result      expected_results_q[$];
    int               words_queued = 0;
    int               words_taken  = 0;
    int               mismatches   = 0;

    bit               sender_bursty   = 1'b0;
    bit               receiver_stalls = 1'b0;
    int               burst_left = 0;
    int               gap_left   = 0;
    logic [31:0]      stall_bits = '1;
    int               stall_count = 0;
    t_pid_result      seen_result;
    t_pid_result      want_result;
    int               last_adc = 0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Setpoint curve over a Q8.8 position; breakpoints tested in order
    function automatic longint curve_setpoint(input longint x);
        longint r;
        if (x < longint'(model_cfg.b1)) begin
            r = 0;
        end else if (x < longint'(model_cfg.b2)) begin
            r = x + longint'(K_LIFT);
        end else if (x < longint'(model_cfg.b3)) begin
            r = ((x * longint'(K_077)) >>> 16) + longint'(K_292);
        end else if (x < longint'(model_cfg.b4)) begin
            r = ((x * longint'(K_059)) >>> 16) + longint'(K_482);
        end else begin
            r = (x >= longint'(K_160)) ? x - longint'(K_160) : 0;
        end
        if (r > 65535) r = 65535;
        return r;
    endfunction

    // One control tick: scale, look up setpoint, update integral, sum PID terms
    function automatic t_pid_result predict_tick(input logic [ADC_W-1:0] adc);
        t_pid_result r;
        longint span, pos, sp, dev, mag, acc, total, drv, lim;
        span = longint'(adc) - longint'(model_cfg.offset);
        if (span < 0) span = 0;
        pos = (span * longint'(model_cfg.scale)) >>> 8;
        if (pos > 65535) pos = 65535;
        sp  = curve_setpoint(pos);
        dev = 10 * (sp - pos);
        mag = (dev < 0) ? -dev : dev;

        // leak harder with no setpoint, hold the integral inside the dead band
        if (sp == 0 || mag >= longint'(K_200)) begin
            if (sp == 0)
                acc = ((longint'(integral_q) * longint'(K_095)) >>> 16) + dev;
            else
                acc = ((longint'(integral_q) * longint'(K_0994)) >>> 16) + dev;
            if (acc > 64'sd2147483647) acc = 64'sd2147483647;
            if (acc < -64'sd2147483648) acc = -64'sd2147483648;
            integral_q = int'(acc);
        end

        total = longint'(model_cfg.gain_p) * dev
              + longint'(model_cfg.gain_i) * longint'(integral_q)
              + longint'(model_cfg.gain_d) * (dev - longint'(prev_dev_q));
        drv = (total >= 0) ? (total >>> 16) : -((-total) >>> 16);
        if (drv > 32767) drv = 32767;
        if (drv < -32768) drv = -32768;

        lim = longint'(model_cfg.limit);
        r.limited = 1'b0;
        if (drv > lim) begin
            drv = lim;
            r.limited = 1'b1;
        end else if (drv < -lim) begin
            drv = -lim;
            r.limited = 1'b1;
        end
        prev_dev_q = int'(dev);

        r.drive_increment = drv[DRV_W-1:0];
        r.position        = pos[POS_W-1:0];
        r.setpoint        = sp[POS_W-1:0];
        return r;
    endfunction

    // Driver: predict each taken word, then offer the next in bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            adc_ch.valid        <= 1'b0;
            adc_ch.cylinder_adc <= '0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (adc_ch.valid && adc_ch.ready) begin
                expected_results_q.push_back(predict_tick(adc_ch.cylinder_adc));
                words_taken++;
            end
            // hold an offered word until it is taken
            if (!adc_ch.valid || adc_ch.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    adc_ch.valid <= 1'b0;
                end else if (adc_words_q.size() > 0) begin
                    adc_ch.valid        <= 1'b1;
                    adc_ch.cylinder_adc <= adc_words_q.pop_front();
                    if (burst_left > 0) begin
                        burst_left--;
                    end else if (sender_bursty) begin
                        burst_left = $urandom_range(0, 15);
                        gap_left   = $urandom_range(1, 20);
                    end
                end else begin
                    adc_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each taken result word, stall on a random pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            drive_ch.ready <= 1'b0;
            stall_count = 0;
        end else begin
            if (drive_ch.valid && drive_ch.ready) begin
                seen_result.drive_increment = drive_ch.drive_increment;
                seen_result.position        = drive_ch.position;
                seen_result.setpoint        = drive_ch.setpoint;
                seen_result.limited         = drive_ch.limited;
                if (expected_results_q.size() == 0) begin
                    $error("unexpected result word: drive_increment %0d",
                           $signed(seen_result.drive_increment));
                    mismatches++;
                end else begin
                    want_result = expected_results_q.pop_front();
                    if (seen_result.drive_increment !== want_result.drive_increment) begin
                        $error("drive_increment: expected %0d, got %0d",
                               $signed(want_result.drive_increment),
                               $signed(seen_result.drive_increment));
                        mismatches++;
                    end
                    if (seen_result.position !== want_result.position) begin
                        $error("position: expected %0d, got %0d",
                               want_result.position, seen_result.position);
                        mismatches++;
                    end
                    if (seen_result.setpoint !== want_result.setpoint) begin
                        $error("setpoint: expected %0d, got %0d",
                               want_result.setpoint, seen_result.setpoint);
                        mismatches++;
                    end
                    if (seen_result.limited !== want_result.limited) begin
                        $error("limited: expected %0d, got %0d",
                               want_result.limited, seen_result.limited);
                        mismatches++;
                    end
                end
            end
            // advance the stall pattern, reload it with a fresh density
            if (stall_count == 0) begin
                case ($urandom_range(0, 3))
                    0: stall_bits = $urandom;
                    1: stall_bits = $urandom | $urandom;
                    2: stall_bits = $urandom & $urandom & $urandom;
                    default: stall_bits = '1;
                endcase
                stall_count = 32;
            end
            drive_ch.ready <= !receiver_stalls || stall_bits[0];
            stall_bits = stall_bits >> 1;
            stall_count--;
        end
    end

    // Register write; the model copy follows at once since the block is idle
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_OFFSET:   model_cfg.offset = data[ADC_W-1:0];
            CFG_SCALE:    model_cfg.scale  = data[15:0];
            CFG_BREAK_LO: {model_cfg.b2, model_cfg.b1} = data;
            CFG_BREAK_HI: {model_cfg.b4, model_cfg.b3} = data;
            CFG_GAIN_P:   model_cfg.gain_p = data[GAIN_W-1:0];
            CFG_GAIN_I:   model_cfg.gain_i = data[GAIN_W-1:0];
            CFG_GAIN_D:   model_cfg.gain_d = data[GAIN_W-1:0];
            CFG_LIMIT:    model_cfg.limit  = data[LIM_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input t_cfg s);
        write_reg(CFG_OFFSET,   CFG_DATA_W'(s.offset));
        write_reg(CFG_SCALE,    CFG_DATA_W'(s.scale));
        write_reg(CFG_BREAK_LO, {s.b2, s.b1});
        write_reg(CFG_BREAK_HI, {s.b4, s.b3});
        write_reg(CFG_GAIN_P,   CFG_DATA_W'(s.gain_p));
        write_reg(CFG_GAIN_I,   CFG_DATA_W'(s.gain_i));
        write_reg(CFG_GAIN_D,   CFG_DATA_W'(s.gain_d));
        write_reg(CFG_LIMIT,    CFG_DATA_W'(s.limit));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic queue_adc(input int adc);
        adc_words_q.push_back(adc[ADC_W-1:0]);
        words_queued++;
    endtask

    // Wait until every word is taken and every result checked, then settle
    task automatic wait_idle();
        while (words_taken != words_queued || expected_results_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic int pick_gain();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 65535;
            2: return $urandom_range(0, 65535);
            default: return $urandom_range(0, 1024);
        endcase
    endfunction

    function automatic t_cfg random_settings();
        t_cfg s;
        int b;
        case ($urandom_range(0, 7))
            0: s.offset = '0;
            1: s.offset = '1;
            2, 3: s.offset = ADC_W'($urandom_range(0, 4095));
            default: s.offset = ADC_W'($urandom_range(0, 512));
        endcase
        case ($urandom_range(0, 7))
            0: s.scale = '0;
            1: s.scale = '1;
            2: s.scale = 16'($urandom_range(0, 65535));
            default: s.scale = 16'($urandom_range(64, 4096));
        endcase
        // mostly ordered breakpoints, sometimes scrambled
        if ($urandom_range(0, 4) == 0) begin
            {s.b2, s.b1} = $urandom;
            {s.b4, s.b3} = $urandom;
        end else begin
            b = $urandom_range(0, 4000);
            s.b1 = POS_W'(b);
            b = b + $urandom_range(0, 16000);
            s.b2 = POS_W'((b > 65535) ? 65535 : b);
            b = b + $urandom_range(0, 20000);
            s.b3 = POS_W'((b > 65535) ? 65535 : b);
            b = b + $urandom_range(0, 30000);
            s.b4 = POS_W'((b > 65535) ? 65535 : b);
        end
        s.gain_p = GAIN_W'(pick_gain());
        s.gain_i = GAIN_W'(pick_gain());
        s.gain_d = GAIN_W'(pick_gain());
        case ($urandom_range(0, 5))
            0: s.limit = '0;
            1: s.limit = '1;
            2: s.limit = LIM_W'($urandom_range(0, 100));
            default: s.limit = LIM_W'($urandom_range(0, 32767));
        endcase
        return s;
    endfunction

    // Random words: ramps around the last sample, uniform, near the offset, ends
    task automatic queue_random(input int count);
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 7))
                0, 1, 2, 3: last_adc = last_adc + $urandom_range(0, 64) - 32;
                4, 5: last_adc = $urandom_range(0, 4095);
                6: last_adc = int'(model_cfg.offset) + $urandom_range(0, 16) - 8;
                default: last_adc = $urandom_range(0, 1) ? 4095 : 0;
            endcase
            if (last_adc < 0) last_adc = 0;
            if (last_adc > 4095) last_adc = 4095;
            queue_adc(last_adc);
        end
    endtask

    // Stimulus
    initial begin
        t_cfg s;
        adc_ch.valid        = 1'b0;
        adc_ch.cylinder_adc = '0;
        drive_ch.ready      = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // registers at reset: everything reads as zero
        queue_adc(0);
        queue_adc(4095);
        wait_idle();

        // every curve segment, sample below and at the rest offset
        s = '0;
        s.offset = 100;   s.scale  = 16'h1000;
        s.b1 = 16'h0100;  s.b2 = 16'h1000;  s.b3 = 16'h3000;  s.b4 = 16'h8000;
        s.gain_p = 16'h0100;  s.gain_i = 16'h0010;  s.gain_d = 16'h0080;
        s.limit = 2000;
        apply_settings(s);
        queue_adc(0);    queue_adc(100);  queue_adc(105);  queue_adc(200);
        queue_adc(500);  queue_adc(1500); queue_adc(4095); queue_adc(4095);
        wait_idle();

        // saturated position, scrambled breakpoints, full gains and limit
        s = '0;
        s.scale = '1;
        s.b1 = 16'h0000;  s.b2 = 16'h0100;  s.b3 = 16'h8000;  s.b4 = 16'h0000;
        s.gain_p = '1;  s.gain_i = '1;  s.gain_d = '1;  s.limit = '1;
        apply_settings(s);
        queue_adc(0);    queue_adc(1);    queue_adc(2);
        queue_adc(200);  queue_adc(4095); queue_adc(4095);
        wait_idle();

        // last segment below its offset floors at zero; zero limit
        s = '0;
        s.scale = 16'h0001;
        s.gain_p = 16'h0800;  s.gain_i = 16'h0800;  s.gain_d = 16'h0800;
        apply_settings(s);
        queue_adc(0);  queue_adc(4095);  queue_adc(4095);  queue_adc(1000);
        wait_idle();

        // lifted segment saturating at full scale, rest offset at the top
        s = '0;
        s.offset = 0;  s.scale = '1;
        s.b1 = 16'h0000;  s.b2 = '1;  s.b3 = '1;  s.b4 = '1;
        s.gain_p = 16'h0100;  s.gain_d = '1;  s.limit = '1;
        apply_settings(s);
        queue_adc(255);  queue_adc(254);  queue_adc(256);
        wait_idle();
        s.offset = '1;
        apply_settings(s);
        queue_adc(4095);  queue_adc(0);
        wait_idle();

        // random settings; the sender pauses midway until all results are in
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            apply_settings(random_settings());
            sender_bursty   = p[0];
            receiver_stalls = p[1];
            queue_random(PHASE_WORDS / 2);
            wait_idle();
            queue_random(PHASE_WORDS - PHASE_WORDS / 2);
            wait_idle();
        end

        if (mismatches == 0 && expected_results_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Run limit
    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

@@ files.f @@
hdl/bbpid_pkg.sv
hdl/bbpid_in_if.sv
hdl/bbpid_out_if.sv
hdl/bbpid_cfg.sv
hdl/bbpid_ctrl.sv
hdl/bbpid_dp.sv
hdl/brake_booster_position_pid.sv
bench/brake_booster_position_pid_test.sv
